>>> rtl/tepq_pkg.sv
// shared types and constants for the timed event priority queue
`timescale 1ns / 1ps
`default_nettype none

package tepq_pkg;

   localparam int KIND_BITS = 2;
   localparam int WAIT_BITS = 31;

   localparam logic [KIND_BITS-1:0] KIND_TICK     = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_SCHEDULE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_POST     = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_PUMP     = 2'd3;

   localparam logic [WAIT_BITS-1:0] WAIT_MAX = '1;

   // per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;
      logic pump;
   } tepq_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/tepq_cell.sv
// one slot of the sorted chain: holds an entry and shifts left or right
`timescale 1ns / 1ps
`default_nettype none

module tepq_cell import tepq_pkg::*; #(
   parameter int TIME_BITS = 32,
   parameter int TAG_BITS  = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tepq_ctrl_type        ctrl,
   input  wire logic [TIME_BITS-1:0] now_ticks,
   input  wire logic [TIME_BITS-1:0] new_due,
   input  wire logic [TIME_BITS-1:0] new_key,
   input  wire logic [TAG_BITS-1:0]  new_tag,
   input  wire logic [TIME_BITS-1:0] left_due,
   input  wire logic [TAG_BITS-1:0]  left_tag,
   input  wire logic                 left_used,
   input  wire logic                 left_after,
   input  wire logic [TIME_BITS-1:0] right_due,
   input  wire logic [TAG_BITS-1:0]  right_tag,
   input  wire logic                 right_used,
   output logic      [TIME_BITS-1:0] due,
   output logic      [TAG_BITS-1:0]  tag,
   output logic                      used,
   output logic                      after
);

   localparam logic [TIME_BITS-1:0] SIGN_BIT = {1'b1, {(TIME_BITS-1){1'b0}}};

   logic [TIME_BITS-1:0] due_ff, due_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;
   logic                 used_ff, used_in;
   logic [TIME_BITS-1:0] key;

   // signed distance from now, biased so unsigned compare gives signed order
   assign key   = (due_ff - now_ticks) ^ SIGN_BIT;
   // new entry sits at or ahead of this slot: first larger key seen so far
   // from the head, or an empty slot
   assign after = left_after || !used_ff || (key > new_key);

   always_comb begin
      due_in  = due_ff;
      tag_in  = tag_ff;
      used_in = used_ff;
      if (ctrl.pump) begin
         due_in  = right_due;
         tag_in  = right_tag;
         used_in = right_used;
      end else if (ctrl.insert && after) begin
         if (!left_after) begin
            due_in  = new_due;
            tag_in  = new_tag;
            used_in = 1'b1;
         end else begin
            due_in  = left_due;
            tag_in  = left_tag;
            used_in = left_used;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      due_ff <= due_in;
      tag_ff <= tag_in;
   end

   assign due  = due_ff;
   assign tag  = tag_ff;
   assign used = used_ff;

endmodule

`default_nettype wire

>>> rtl/timed_event_priority_queue.sv
// top level: time counter, chain of sorted cells, response register
// each response is held in the pending register and then in the response register
// throughput: one item per cycle unless responses stall; every cell compares with the
//   new key in parallel, so only the pending-response register can hold off a request
// reset clears the time counter, the pending flag, every slot's used flag and the
//   response valid; slot times and tags are left as they are
`timescale 1ns / 1ps
`default_nettype none

module timed_event_priority_queue import tepq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_BITS   = 32,
   parameter int TAG_BITS    = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [KIND_BITS-1:0] req_kind,
   input  wire logic [30:0]          req_interval,
   input  wire logic [TAG_BITS-1:0]  req_tag,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_delivered,
   output logic      [TAG_BITS-1:0]  rsp_out_tag,
   output logic      [WAIT_BITS-1:0] rsp_wait_ticks,
   output logic                      rsp_queue_empty,
   output logic                      rsp_dropped
);

   localparam logic [TIME_BITS-1:0] SIGN_BIT = {1'b1, {(TIME_BITS-1){1'b0}}};
   localparam int EXT_BITS = (TIME_BITS > WAIT_BITS + 1) ? TIME_BITS : WAIT_BITS + 1;

   logic [TIME_BITS-1:0] now_ff, now_in;

   logic [TIME_BITS-1:0] cell_due   [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]  cell_tag   [QUEUE_DEPTH];
   logic                 cell_used  [QUEUE_DEPTH];
   logic                 cell_after [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] used_vec;

   tepq_ctrl_type        ctrl;
   logic                 accept;
   logic                 is_insert;
   logic                 full;
   logic                 head_due;
   logic [TIME_BITS-1:0] head_diff;
   logic [TIME_BITS-1:0] new_off;
   logic [TIME_BITS-1:0] new_due;
   logic [TIME_BITS-1:0] new_key;

   logic                 pend_ff, pend_in;
   logic                 pend_delivered_ff, pend_delivered_in;
   logic [TAG_BITS-1:0]  pend_tag_ff, pend_tag_in;
   logic                 pend_dropped_ff, pend_dropped_in;
   logic                 load_rsp;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_delivered_ff;
   logic [TAG_BITS-1:0]  rsp_out_tag_ff;
   logic [WAIT_BITS-1:0] rsp_wait_ff, wait_in;
   logic                 rsp_empty_ff;
   logic                 rsp_dropped_ff;
   logic [EXT_BITS-1:0]  wait_pos;

   // handshake
   assign load_rsp  = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = pend_ff && !load_rsp;
   assign accept    = req_valid && !req_stall;

   // decode of the accepted item
   assign full      = cell_used[QUEUE_DEPTH-1];
   assign head_diff = cell_due[0] - now_ff;
   assign head_due  = head_diff[TIME_BITS-1] || (head_diff == '0);
   assign is_insert = (req_kind == KIND_SCHEDULE) || (req_kind == KIND_POST);
   assign new_off   = (req_kind == KIND_SCHEDULE) ? TIME_BITS'(req_interval) : '0;
   assign new_due   = now_ff + new_off;
   assign new_key   = new_off ^ SIGN_BIT;

   always_comb begin
      ctrl.insert = accept && is_insert && !full;
      ctrl.pump   = accept && (req_kind == KIND_PUMP) && cell_used[0] && head_due;
   end

   assign now_in = (accept && (req_kind == KIND_TICK)) ? now_ff + 1'b1 : now_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
      end else begin
         now_ff <= now_in;
      end
   end

   // cell chain
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic [TIME_BITS-1:0] l_due, r_due;
      logic [TAG_BITS-1:0]  l_tag, r_tag;
      logic                 l_used, l_after, r_used;

      if (g == 0) begin : g_head
         assign l_due   = '0;
         assign l_tag   = '0;
         assign l_used  = 1'b0;
         assign l_after = 1'b0;
      end else begin : g_mid
         assign l_due   = cell_due[g-1];
         assign l_tag   = cell_tag[g-1];
         assign l_used  = cell_used[g-1];
         assign l_after = cell_after[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_tail
         assign r_due  = '0;
         assign r_tag  = '0;
         assign r_used = 1'b0;
      end else begin : g_body
         assign r_due  = cell_due[g+1];
         assign r_tag  = cell_tag[g+1];
         assign r_used = cell_used[g+1];
      end

      tepq_cell #(
         .TIME_BITS (TIME_BITS),
         .TAG_BITS  (TAG_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .now_ticks  (now_ff),
         .new_due    (new_due),
         .new_key    (new_key),
         .new_tag    (req_tag),
         .left_due   (l_due),
         .left_tag   (l_tag),
         .left_used  (l_used),
         .left_after (l_after),
         .right_due  (r_due),
         .right_tag  (r_tag),
         .right_used (r_used),
         .due        (cell_due[g]),
         .tag        (cell_tag[g]),
         .used       (cell_used[g]),
         .after      (cell_after[g])
      );

      assign used_vec[g] = cell_used[g];
   end

   // pending result of the last transfer, finished once the chain has settled
   assign pend_in           = accept || (pend_ff && !load_rsp);
   assign pend_delivered_in = ctrl.pump;
   assign pend_tag_in       = ctrl.pump ? cell_tag[0] : '0;
   assign pend_dropped_in   = accept && is_insert && full;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_delivered_ff <= pend_delivered_in;
         pend_tag_ff       <= pend_tag_in;
         pend_dropped_ff   <= pend_dropped_in;
      end
   end

   // head wait from the settled state, saturated to the port width
   assign wait_pos = EXT_BITS'(head_diff[TIME_BITS-2:0]);

   always_comb begin
      if (!cell_used[0] || head_diff[TIME_BITS-1]) begin
         wait_in = '0;
      end else if (wait_pos > EXT_BITS'(WAIT_MAX)) begin
         wait_in = WAIT_MAX;
      end else begin
         wait_in = WAIT_BITS'(wait_pos);
      end
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_delivered_ff <= pend_delivered_ff;
         rsp_out_tag_ff   <= pend_tag_ff;
         rsp_wait_ff      <= wait_in;
         rsp_empty_ff     <= !cell_used[0];
         rsp_dropped_ff   <= pend_dropped_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_delivered   = rsp_delivered_ff;
   assign rsp_out_tag     = rsp_out_tag_ff;
   assign rsp_wait_ticks  = rsp_wait_ff;
   assign rsp_queue_empty = rsp_empty_ff;
   assign rsp_dropped     = rsp_dropped_ff;

   // occupied slots always form a prefix of the chain
   a_used_prefix: assert property (@(posedge clock) disable iff (reset)
      (used_vec[QUEUE_DEPTH-1:1] & ~used_vec[QUEUE_DEPTH-2:0]) == '0)
      else $error("used slots are not contiguous from the head");

   // every request transfer leaves a pending result behind it
   a_pend_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> pend_ff)
      else $error("request transfer without pending result");

   // insert and pump never happen on the same item
   a_ctrl_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.insert && ctrl.pump))
      else $error("insert and pump issued together");

   // a pump on a full chain leaves the last slot free in the next cycle
   a_pump_frees_tail: assert property (@(posedge clock) disable iff (reset)
      (ctrl.pump && full) |=> !cell_used[QUEUE_DEPTH-1])
      else $error("pump did not free the tail slot");

endmodule

`default_nettype wire
